@@ rtl/core/volume_sum_pyramid_3d_core_defines.svh @@
`ifndef VOLUME_SUM_PYRAMID_3D_CORE_DEFINES_SVH
`define VOLUME_SUM_PYRAMID_3D_CORE_DEFINES_SVH

// Implication checked in the same cycle, outside reset.
`define VSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, outside reset.
`define VSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/vsp_pkg.sv @@
package vsp_pkg;

  // Field widths of the request and result items.
  localparam int REQ_W     = 2;
  localparam int LEVEL_W   = 3;
  localparam int COORD_W   = 6;
  localparam int HI_W      = 5;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;

  // Request type codes.
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Z = 2'd2;

  // Reset value of each base size register.
  localparam int BASE_SIZE_RESET = 32;

  // Operations handed from the front end to the engine.
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_ADD,
    OP_READ,
    OP_UPDATE,
    OP_REJECT
  } op_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [LEVEL_W-1:0] level;
    logic [COORD_W-1:0] x_lo;
    logic [COORD_W-1:0] y_lo;
    logic [COORD_W-1:0] z_lo;
    logic [HI_W-1:0]    x_hi;
    logic [HI_W-1:0]    y_hi;
    logic [HI_W-1:0]    z_hi;
    logic [DATA_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              status;
  } out_item_t;

  typedef struct packed {
    op_t                op;
    logic [LEVEL_W-1:0] level;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [HI_W-1:0]    xh;
    logic [HI_W-1:0]    yh;
    logic [HI_W-1:0]    zh;
    logic [DATA_W-1:0]  value;
  } q_item_t;

  typedef struct packed {
    logic clear_done;
    logic levels_busy;
  } core_status_t;

endpackage

@@ rtl/core/vsp_ram.sv @@
module vsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/vsp_levels.sv @@
module vsp_levels #(
  parameter int MAX_SIDE   = 32,
  parameter int MAX_LEVELS = 6,
  parameter int SIDE_W     = 6,
  parameter int ADDR_W     = 16,
  parameter int LVL_CNT_W  = 3,
  parameter int IDX_W      = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vsp_pkg::CFG_W-1:0]       cfg_data,
  input  logic [IDX_W-1:0]                rd_idx,
  output logic                            busy,
  output logic [LVL_CNT_W-1:0]            level_count,
  output logic [ADDR_W-1:0]               tab_start,
  output logic [SIDE_W-1:0]               tab_sx,
  output logic [SIDE_W-1:0]               tab_sy,
  output logic [SIDE_W-1:0]               tab_sz,
  output logic [2*SIDE_W-1:0]             tab_plane
);
  import vsp_pkg::*;

  logic [CFG_W-1:0]    base_x, base_y, base_z;
  logic [CFG_W-1:0]    bx_next, by_next, bz_next;
  logic                cfg_hit;
  logic                phase;
  logic [IDX_W-1:0]    k;
  logic [SIDE_W-1:0]   cur_x, cur_y, cur_z;
  logic [ADDR_W-1:0]   cur_start;
  logic [2*SIDE_W-1:0] cur_plane;
  logic                cur_wide;

  logic [ADDR_W-1:0]   start_tab [MAX_LEVELS];
  logic [SIDE_W-1:0]   sx_tab    [MAX_LEVELS];
  logic [SIDE_W-1:0]   sy_tab    [MAX_LEVELS];
  logic [SIDE_W-1:0]   sz_tab    [MAX_LEVELS];
  logic [2*SIDE_W-1:0] plane_tab [MAX_LEVELS];

  // A size of zero acts as one, a size above the maximum side as the maximum.
  function automatic logic [SIDE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (int'(v) > MAX_SIDE) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

  // Next side length: half, rounded up.
  function automatic logic [SIDE_W-1:0] half_up(input logic [SIDE_W-1:0] v);
    logic [SIDE_W:0] s;
    s = {1'b0, v} + (SIDE_W+1)'(1);
    return s[SIDE_W:1];
  endfunction

  // Register writes that land on a defined index.
  always_comb begin
    bx_next = base_x;
    by_next = base_y;
    bz_next = base_z;
    cfg_hit = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_X: begin bx_next = cfg_data; cfg_hit = 1'b1; end
        REG_BASE_Y: begin by_next = cfg_data; cfg_hit = 1'b1; end
        REG_BASE_Z: begin bz_next = cfg_data; cfg_hit = 1'b1; end
        default: ;
      endcase
    end
  end

  assign cur_wide = (cur_x > SIDE_W'(1)) || (cur_y > SIDE_W'(1)) || (cur_z > SIDE_W'(1));

  // Rebuild the table one level at a time: plane first, then volume.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_x      <= CFG_W'(BASE_SIZE_RESET);
      base_y      <= CFG_W'(BASE_SIZE_RESET);
      base_z      <= CFG_W'(BASE_SIZE_RESET);
      busy        <= 1'b1;
      phase       <= 1'b0;
      k           <= '0;
      cur_x       <= eff_size(CFG_W'(BASE_SIZE_RESET));
      cur_y       <= eff_size(CFG_W'(BASE_SIZE_RESET));
      cur_z       <= eff_size(CFG_W'(BASE_SIZE_RESET));
      cur_start   <= '0;
      level_count <= LVL_CNT_W'(1);
    end else if (cfg_hit) begin
      base_x      <= bx_next;
      base_y      <= by_next;
      base_z      <= bz_next;
      busy        <= 1'b1;
      phase       <= 1'b0;
      k           <= '0;
      cur_x       <= eff_size(bx_next);
      cur_y       <= eff_size(by_next);
      cur_z       <= eff_size(bz_next);
      cur_start   <= '0;
      level_count <= LVL_CNT_W'(1);
    end else if (busy) begin
      if (!phase) begin
        cur_plane <= (2*SIDE_W)'(cur_x) * (2*SIDE_W)'(cur_y);
        phase     <= 1'b1;
      end else begin
        start_tab[k] <= cur_start;
        sx_tab[k]    <= cur_x;
        sy_tab[k]    <= cur_y;
        sz_tab[k]    <= cur_z;
        plane_tab[k] <= cur_plane;
        cur_start    <= cur_start + ADDR_W'(ADDR_W'(cur_plane) * ADDR_W'(cur_z));
        cur_x        <= half_up(cur_x);
        cur_y        <= half_up(cur_y);
        cur_z        <= half_up(cur_z);
        phase        <= 1'b0;
        if (int'(k) < MAX_LEVELS - 1 && cur_wide) begin
          level_count <= level_count + LVL_CNT_W'(1);
        end
        if (int'(k) == MAX_LEVELS - 1) begin
          busy <= 1'b0;
        end else begin
          k <= k + IDX_W'(1);
        end
      end
    end
  end

  // Single read port of the table.
  assign tab_start = start_tab[rd_idx];
  assign tab_sx    = sx_tab[rd_idx];
  assign tab_sy    = sy_tab[rd_idx];
  assign tab_sz    = sz_tab[rd_idx];
  assign tab_plane = plane_tab[rd_idx];

endmodule

@@ rtl/core/vsp_queue.sv @@
module vsp_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vsp_pkg::q_item_t  push_item,
  input  logic              pop,
  output vsp_pkg::q_item_t  head,
  output logic              empty,
  output logic              full
);
  import vsp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign empty = (count == '0);
  assign full  = (int'(count) == DEPTH);
  assign head  = entries[rd_ptr];

  // Circular buffer between front end and engine.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_item;
        wr_ptr <= (int'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/vsp_front.sv @@
module vsp_front #(
  parameter int LVL_CNT_W = 3
) (
  input  logic                    in_valid,
  output logic                    in_ready,
  input  vsp_pkg::in_item_t       in_item,
  input  vsp_pkg::core_status_t   status,
  input  logic [LVL_CNT_W-1:0]    level_count,
  input  logic                    q_full,
  output logic                    push,
  output vsp_pkg::q_item_t        push_item
);
  import vsp_pkg::*;

  logic lvl_bad;

  // Requests are taken once the store is cleared, the level table stands and the queue has room.
  assign in_ready = status.clear_done && !status.levels_busy && !q_full;
  assign push     = in_valid && in_ready;
  assign lvl_bad  = int'(in_item.level) >= int'(level_count);

  // Classify each request and fold the vertex shift of an add into its coordinates.
  always_comb begin
    push_item.level = in_item.level;
    push_item.x     = in_item.x_lo;
    push_item.y     = in_item.y_lo;
    push_item.z     = in_item.z_lo;
    push_item.xh    = in_item.x_hi;
    push_item.yh    = in_item.y_hi;
    push_item.zh    = in_item.z_hi;
    push_item.value = in_item.value;
    unique case (in_item.req_type)
      REQ_WRITE: push_item.op = OP_WRITE;
      REQ_ADD: begin
        push_item.op = OP_ADD;
        push_item.x  = in_item.x_lo >> 1;
        push_item.y  = in_item.y_lo >> 1;
        push_item.z  = in_item.z_lo >> 1;
      end
      REQ_READ:   push_item.op = lvl_bad ? OP_REJECT : OP_READ;
      REQ_UPDATE: push_item.op = lvl_bad ? OP_REJECT : OP_UPDATE;
      default:    push_item.op = OP_REJECT;
    endcase
  end

endmodule

@@ rtl/core/vsp_back.sv @@
`include "volume_sum_pyramid_3d_core_defines.svh"

module vsp_back #(
  parameter int SIDE_W      = 6,
  parameter int ADDR_W      = 16,
  parameter int STORE_DEPTH = 37449,
  parameter int LVL_CNT_W   = 3,
  parameter int IDX_W       = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       levels_busy,
  input  logic [LVL_CNT_W-1:0]       level_count,
  input  logic [ADDR_W-1:0]          tab_start,
  input  logic [SIDE_W-1:0]          tab_sx,
  input  logic [SIDE_W-1:0]          tab_sy,
  input  logic [SIDE_W-1:0]          tab_sz,
  input  logic [2*SIDE_W-1:0]        tab_plane,
  output logic [IDX_W-1:0]           rd_idx,
  input  vsp_pkg::q_item_t           q_head,
  input  logic                       q_empty,
  output logic                       pop,
  output logic                       clear_done,
  output logic                       out_valid,
  input  logic                       out_ready,
  output vsp_pkg::out_item_t         out_item
);
  import vsp_pkg::*;

  localparam int CW = (SIDE_W > COORD_W) ? SIDE_W : COORD_W;
  localparam int TW = CW + SIDE_W + 2;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_ADR1, S_ADR2, S_MEM, S_RWAIT,
    S_LVL, S_LCHI, S_LPAR, S_RANGE, S_PADR1, S_PADR2, S_CRD, S_CACC,
    S_PWR, S_OUT
  } state_t;

  state_t              state;
  op_t                 op;
  logic [ADDR_W-1:0]   clr_addr;
  logic [LVL_CNT_W-1:0] lv;
  logic [CW-1:0]       xl, yl, zl, xh, yh, zh, ex, ey, ez, cx, cy, cz;
  logic [DATA_W-1:0]   val, acc;
  logic [ADDR_W-1:0]   pstart, cstart, addr, paddr, cbase;
  logic [SIDE_W-1:0]   psx, psy, psz, csx, csy, csz;
  logic [2*SIDE_W-1:0] cplane;
  logic [TW-1:0]       t1, t2;
  logic                inr, cinr;
  logic [2:0]          c;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata;
  logic                child_in;
  logic [ADDR_W-1:0]   child_addr;
  logic [CW-1:0]       ex_new, ey_new, ez_new;

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? '1 : s[DATA_W-1:0];
  endfunction

  // Inclusive region end clamped to the level size.
  function automatic logic [CW-1:0] clamp_hi(input logic [CW-1:0] h,
                                             input logic [SIDE_W-1:0] s);
    logic [CW-1:0] r;
    if (int'(h) < int'(s) - 1) begin
      r = h;
    end else begin
      r = CW'(s - SIDE_W'(1));
    end
    return r;
  endfunction

  assign ex_new = clamp_hi(xh, psx);
  assign ey_new = clamp_hi(yh, psy);
  assign ez_new = clamp_hi(zh, psz);

  // Child c of the current parent: bit 0 steps x, bit 1 steps y, bit 2 steps z.
  assign child_in = (int'({cx, c[0]}) < int'(csx)) && (int'({cy, c[1]}) < int'(csy)) &&
                    (int'({cz, c[2]}) < int'(csz));
  assign child_addr = cbase + ADDR_W'(c[0]) + (c[1] ? ADDR_W'(csx) : '0) +
                      (c[2] ? ADDR_W'(cplane) : '0);

  assign pop        = (state == S_IDLE) && !q_empty && !levels_busy;
  assign clear_done = (state != S_CLEAR);
  assign out_valid  = (state == S_OUT);

  // Memory port control for each state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = val;
    ram_re    = 1'b0;
    ram_raddr = addr;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_MEM: begin
        ram_we = inr && (op == OP_WRITE);
        ram_re = inr && (op != OP_WRITE);
      end
      S_RWAIT: begin
        ram_we    = (op == OP_ADD);
        ram_wdata = sat_add(ram_rdata, val);
      end
      S_CRD: begin
        ram_re    = child_in;
        ram_raddr = child_addr;
      end
      S_PWR: begin
        ram_we    = 1'b1;
        ram_waddr = paddr;
        ram_wdata = acc;
      end
      default: ;
    endcase
  end

  // Engine sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (int'(clr_addr) == STORE_DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            op       <= q_head.op;
            val      <= q_head.value;
            cx       <= CW'(q_head.x);
            cy       <= CW'(q_head.y);
            cz       <= CW'(q_head.z);
            xl       <= CW'(q_head.x);
            yl       <= CW'(q_head.y);
            zl       <= CW'(q_head.z);
            xh       <= CW'(q_head.xh);
            yh       <= CW'(q_head.yh);
            zh       <= CW'(q_head.zh);
            lv       <= LVL_CNT_W'(q_head.level);
            out_item <= '{read_value: '0, status: 1'b0};
            unique case (q_head.op)
              OP_WRITE, OP_ADD: begin
                rd_idx <= '0;
                state  <= S_LOAD;
              end
              OP_READ: begin
                rd_idx <= IDX_W'(q_head.level);
                state  <= S_LOAD;
              end
              OP_UPDATE: state <= S_LVL;
              default: begin
                out_item <= '{read_value: '0, status: 1'b1};
                state    <= S_OUT;
              end
            endcase
          end
        end
        S_LOAD: begin
          pstart <= tab_start;
          psx    <= tab_sx;
          psy    <= tab_sy;
          psz    <= tab_sz;
          state  <= S_ADR1;
        end
        S_ADR1: begin
          t1    <= TW'(TW'(cz) * TW'(psy) + TW'(cy));
          inr   <= (int'(cx) < int'(psx)) && (int'(cy) < int'(psy)) && (int'(cz) < int'(psz));
          state <= S_ADR2;
        end
        S_ADR2: begin
          addr  <= pstart + ADDR_W'(ADDR_W'(t1) * ADDR_W'(psx)) + ADDR_W'(cx);
          state <= S_MEM;
        end
        S_MEM: begin
          state <= (inr && op != OP_WRITE) ? S_RWAIT : S_OUT;
        end
        S_RWAIT: begin
          if (op == OP_READ) begin
            out_item.read_value <= ram_rdata;
          end
          state <= S_OUT;
        end
        // Region update, one level at a time from the start level upward.
        S_LVL: begin
          if (lv >= level_count) begin
            state <= S_OUT;
          end else if (lv == '0) begin
            xl <= xl >> 1; yl <= yl >> 1; zl <= zl >> 1;
            xh <= xh >> 1; yh <= yh >> 1; zh <= zh >> 1;
            lv <= lv + LVL_CNT_W'(1);
          end else begin
            rd_idx <= IDX_W'(lv - LVL_CNT_W'(1));
            state  <= S_LCHI;
          end
        end
        S_LCHI: begin
          cstart <= tab_start;
          csx    <= tab_sx;
          csy    <= tab_sy;
          csz    <= tab_sz;
          cplane <= tab_plane;
          rd_idx <= IDX_W'(lv);
          state  <= S_LPAR;
        end
        S_LPAR: begin
          pstart <= tab_start;
          psx    <= tab_sx;
          psy    <= tab_sy;
          psz    <= tab_sz;
          state  <= S_RANGE;
        end
        S_RANGE: begin
          ex <= ex_new;
          ey <= ey_new;
          ez <= ez_new;
          cx <= xl;
          cy <= yl;
          cz <= zl;
          if (xl > ex_new || yl > ey_new || zl > ez_new) begin
            xl <= xl >> 1; yl <= yl >> 1; zl <= zl >> 1;
            xh <= xh >> 1; yh <= yh >> 1; zh <= zh >> 1;
            lv <= lv + LVL_CNT_W'(1);
            state <= S_LVL;
          end else begin
            state <= S_PADR1;
          end
        end
        S_PADR1: begin
          t1    <= TW'(TW'(cz) * TW'(psy) + TW'(cy));
          t2    <= TW'(TW'({cz, 1'b0}) * TW'(csy) + TW'({cy, 1'b0}));
          state <= S_PADR2;
        end
        S_PADR2: begin
          paddr <= pstart + ADDR_W'(ADDR_W'(t1) * ADDR_W'(psx)) + ADDR_W'(cx);
          cbase <= cstart + ADDR_W'(ADDR_W'(t2) * ADDR_W'(csx)) + ADDR_W'({cx, 1'b0});
          c     <= '0;
          acc   <= '0;
          state <= S_CRD;
        end
        S_CRD: begin
          cinr  <= child_in;
          state <= S_CACC;
        end
        S_CACC: begin
          acc <= sat_add(acc, cinr ? ram_rdata : '0);
          if (c == 3'd7) begin
            state <= S_PWR;
          end else begin
            c     <= c + 3'd1;
            state <= S_CRD;
          end
        end
        S_PWR: begin
          state <= S_PADR1;
          if (cx < ex) begin
            cx <= cx + CW'(1);
          end else begin
            cx <= xl;
            if (cy < ey) begin
              cy <= cy + CW'(1);
            end else begin
              cy <= yl;
              if (cz < ez) begin
                cz <= cz + CW'(1);
              end else begin
                xl <= xl >> 1; yl <= yl >> 1; zl <= zl >> 1;
                xh <= xh >> 1; yh <= yh >> 1; zh <= zh >> 1;
                lv <= lv + LVL_CNT_W'(1);
                state <= S_LVL;
              end
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  vsp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr[$clog2(STORE_DEPTH)-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr[$clog2(STORE_DEPTH)-1:0]),
    .rdata (ram_rdata)
  );

  // The sequencer never reads and writes the store in the same cycle.
  `VSP_ASSERT_NOW(a_no_rw_clash, ram_we, !ram_re, "store read and write in one cycle")
  // A rejected request never carries read data.
  `VSP_ASSERT_NOW(a_reject_zero, out_valid && out_item.status, out_item.read_value == '0, "rejected request with data")
  // Taking a request always leaves the idle state.
  `VSP_ASSERT_NEXT(a_pop_busy, pop, state != S_IDLE, "request taken but engine stayed idle")

endmodule

@@ rtl/core/volume_sum_pyramid_3d_core.sv @@
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_we                 cfg_index, cfg_data
// in       in         in_valid / in_ready    in_item (vsp_pkg::in_item_t)
// out      out        out_valid / out_ready  out_item (vsp_pkg::out_item_t)
//
// After reset the store is cleared one entry per cycle over all STORE_DEPTH
// entries (41744 at the default sizes); no request is taken until that pass ends.
// A size register write rebuilds the level table.
// Write, read and add pass the level table load and the address multiplies;
// read and add also wait on the registered store read. A region update
// loads and clamps per level (level 0 is passed over), then per rebuilt entry
// does eight child reads on the one read port, each followed by a saturating add.
// Requests queue in a two-entry buffer, so input is taken while a result stalls.
module volume_sum_pyramid_3d_core #(
  parameter int MAX_SIDE   = 32,
  parameter int MAX_LEVELS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [vsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vsp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  vsp_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output vsp_pkg::out_item_t            out_item
);
  import vsp_pkg::*;

  localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
  localparam int STORE_DEPTH = (MAX_SIDE * MAX_SIDE * MAX_SIDE * 8) / 7 +
                               4 * MAX_SIDE * MAX_SIDE + 6 * MAX_SIDE + MAX_LEVELS + 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LVL_CNT_W   = $clog2(MAX_LEVELS + 1);
  localparam int IDX_W       = $clog2(MAX_LEVELS);

  core_status_t          status;
  logic                  levels_busy, clear_done;
  logic [LVL_CNT_W-1:0]  level_count;
  logic [IDX_W-1:0]      rd_idx;
  logic [ADDR_W-1:0]     tab_start;
  logic [SIDE_W-1:0]     tab_sx, tab_sy, tab_sz;
  logic [2*SIDE_W-1:0]   tab_plane;
  logic                  push, pop, q_empty, q_full;
  q_item_t               push_item, q_head;

  assign status = '{clear_done: clear_done, levels_busy: levels_busy};

  vsp_levels #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_LEVELS (MAX_LEVELS),
    .SIDE_W     (SIDE_W),
    .ADDR_W     (ADDR_W),
    .LVL_CNT_W  (LVL_CNT_W),
    .IDX_W      (IDX_W)
  ) u_levels (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rd_idx      (rd_idx),
    .busy        (levels_busy),
    .level_count (level_count),
    .tab_start   (tab_start),
    .tab_sx      (tab_sx),
    .tab_sy      (tab_sy),
    .tab_sz      (tab_sz),
    .tab_plane   (tab_plane)
  );

  vsp_front #(
    .LVL_CNT_W (LVL_CNT_W)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .status      (status),
    .level_count (level_count),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  vsp_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  vsp_back #(
    .SIDE_W      (SIDE_W),
    .ADDR_W      (ADDR_W),
    .STORE_DEPTH (STORE_DEPTH),
    .LVL_CNT_W   (LVL_CNT_W),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .levels_busy (levels_busy),
    .level_count (level_count),
    .tab_start   (tab_start),
    .tab_sx      (tab_sx),
    .tab_sy      (tab_sy),
    .tab_sz      (tab_sz),
    .tab_plane   (tab_plane),
    .rd_idx      (rd_idx),
    .q_head      (q_head),
    .q_empty     (q_empty),
    .pop         (pop),
    .clear_done  (clear_done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule

@@ sim/volume_sum_pyramid_3d_core_tb.sv @@
module volume_sum_pyramid_3d_core_tb;
  import vsp_pkg::*;

  localparam int SIDE_MAX    = 32;
  localparam int LEVELS_MAX  = 6;
  localparam int PYR_DEPTH   = (SIDE_MAX * SIDE_MAX * SIDE_MAX * 8) / 7
                               + 4 * SIDE_MAX * SIDE_MAX + 6 * SIDE_MAX + LEVELS_MAX + 1;
  localparam int PHASE_ITEMS = 170;
  localparam int HOLD_CYCLES = 400;
  localparam int IN_W        = $bits(in_item_t);

  // Pyramid predictor and result checker.
  class pyramid_scoreboard;
    bit [31:0] pyr[PYR_DEPTH];
    int        reg_size[3];
    int        lv_start[LEVELS_MAX];
    int        lv_sx[LEVELS_MAX];
    int        lv_sy[LEVELS_MAX];
    int        lv_sz[LEVELS_MAX];
    int        lv_count;
    out_item_t expected_results[$];
    int        fails;

    function void init();
      foreach (pyr[i]) pyr[i] = '0;
      for (int i = 0; i < 3; i++) reg_size[i] = BASE_SIZE_RESET;
      fails = 0;
      rebuild_levels();
    endfunction

    function int clamp_side(int v);
      if (v == 0) return 1;
      if (v > SIDE_MAX) return SIDE_MAX;
      return v;
    endfunction

    // Level sizes halve rounding up; the count covers the largest side.
    function void rebuild_levels();
      int sx, sy, sz, m, p, base;
      sx = clamp_side(reg_size[0]);
      sy = clamp_side(reg_size[1]);
      sz = clamp_side(reg_size[2]);
      m = sx > sy ? sx : sy;
      if (sz > m) m = sz;
      lv_count = 1;
      p = 1;
      while (p < m) begin
        p = p * 2;
        lv_count++;
      end
      if (lv_count > LEVELS_MAX) lv_count = LEVELS_MAX;
      base = 0;
      for (int i = 0; i < LEVELS_MAX; i++) begin
        lv_start[i] = base;
        lv_sx[i] = sx;
        lv_sy[i] = sy;
        lv_sz[i] = sz;
        base += sx * sy * sz;
        sx = (sx + 1) / 2;
        sy = (sy + 1) / 2;
        sz = (sz + 1) / 2;
      end
    endfunction

    function void set_size(int idx, int v);
      reg_size[idx] = v & 63;
      rebuild_levels();
    endfunction

    function int grid_entries();
      return lv_sx[0] * lv_sy[0] * lv_sz[0];
    endfunction

    function bit find_entry(int lv, int x, int y, int z, output int idx);
      idx = 0;
      if (lv >= LEVELS_MAX) return 0;
      if (x >= lv_sx[lv] || y >= lv_sy[lv] || z >= lv_sz[lv]) return 0;
      idx = lv_start[lv] + (z * lv_sy[lv] + y) * lv_sx[lv] + x;
      return idx < PYR_DEPTH;
    endfunction

    function bit [31:0] sat_sum(bit [31:0] a, bit [31:0] b);
      bit [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function bit [31:0] entry_at(int lv, int x, int y, int z);
      int idx;
      if (!find_entry(lv, x, y, z, idx)) return '0;
      return pyr[idx];
    endfunction

    // Rebuild each covered entry from its eight children, level by level.
    function void rebuild_region(int lv, int xl, int yl, int zl, int xh, int yh, int zh);
      int ex, ey, ez, idx;
      bit [31:0] s;
      for (; lv < lv_count; lv++) begin
        if (lv != 0) begin
          ex = xh < lv_sx[lv] - 1 ? xh : lv_sx[lv] - 1;
          ey = yh < lv_sy[lv] - 1 ? yh : lv_sy[lv] - 1;
          ez = zh < lv_sz[lv] - 1 ? zh : lv_sz[lv] - 1;
          for (int z = zl; z <= ez; z++)
            for (int y = yl; y <= ey; y++)
              for (int x = xl; x <= ex; x++) begin
                s = '0;
                for (int c = 0; c < 8; c++)
                  s = sat_sum(s, entry_at(lv - 1, 2 * x + (c & 1), 2 * y + ((c >> 1) & 1),
                                          2 * z + ((c >> 2) & 1)));
                if (find_entry(lv, x, y, z, idx)) pyr[idx] = s;
              end
        end
        xl >>= 1; yl >>= 1; zl >>= 1;
        xh >>= 1; yh >>= 1; zh >>= 1;
      end
    endfunction

    // An accepted request updates the store and queues its response.
    function void note_input(in_item_t it);
      out_item_t rsp;
      int idx;
      rsp = '0;
      case (it.req_type)
        REQ_WRITE: begin
          if (find_entry(0, it.x_lo, it.y_lo, it.z_lo, idx)) pyr[idx] = it.value;
        end
        REQ_ADD: begin
          if (find_entry(0, it.x_lo >> 1, it.y_lo >> 1, it.z_lo >> 1, idx))
            pyr[idx] = sat_sum(pyr[idx], it.value);
        end
        REQ_READ: begin
          if (it.level >= lv_count) rsp.status = 1'b1;
          else rsp.read_value = entry_at(it.level, it.x_lo, it.y_lo, it.z_lo);
        end
        default: begin
          if (it.level >= lv_count) rsp.status = 1'b1;
          else rebuild_region(it.level, it.x_lo, it.y_lo, it.z_lo, it.x_hi, it.y_hi, it.z_hi);
        end
      endcase
      expected_results.push_back(rsp);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected response: read_value %h status %0d",
                                  got.read_value, got.status);
        return;
      end
      want = expected_results.pop_front();
      if (got.read_value !== want.read_value || got.status !== want.status) begin
        fails++;
        if (fails <= 10)
          $display("response mismatch: expected read_value %h status %0d, got %h %0d",
                   want.read_value, want.status, got.read_value, got.status);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;

  pyramid_scoreboard sb;
  bit                back_to_back;

  volume_sum_pyramid_3d_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("simulation failed");
    $finish;
  end

  // Offer one request after a gap and wait for its transfer.
  task automatic send_request(in_item_t it);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sb.note_input(it);
  endtask

  // Size registers change only with the block idle.
  task automatic write_sizes(int sx, int sy, int sz);
    int vals[3];
    vals = '{sx, sy, sz};
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= (i == 0) ? REG_BASE_X : (i == 1) ? REG_BASE_Y : REG_BASE_Z;
      cfg_data <= CFG_W'(vals[i]);
      @(posedge clk);
      cfg_we <= 1'b0;
      sb.set_size(i, vals[i]);
      repeat (16) @(posedge clk);
    end
  endtask

  function automatic in_item_t make_req(logic [1:0] rt, int lv, int x, int y, int z,
                                        int xh, int yh, int zh, logic [31:0] v);
    in_item_t it;
    it.req_type = rt;
    it.level = LEVEL_W'(lv);
    it.x_lo = COORD_W'(x);
    it.y_lo = COORD_W'(y);
    it.z_lo = COORD_W'(z);
    it.x_hi = HI_W'(xh);
    it.y_hi = HI_W'(yh);
    it.z_hi = HI_W'(zh);
    it.value = v;
    return it;
  endfunction

  function automatic int near_hi(int lo);
    int h;
    h = (lo > 31 ? 31 : lo) + $urandom_range(0, 2);
    return h > 31 ? 31 : h;
  endfunction

  // Mostly well-formed requests inside the current grid; some raw noise.
  function automatic in_item_t random_request();
    in_item_t it;
    int lv, sel;
    bit small_grid;
    small_grid = sb.grid_entries() <= 700;
    if ($urandom_range(0, 9) == 0) begin
      it = IN_W'({$urandom, $urandom, $urandom});
      if (it.level > 5) it.level = LEVEL_W'($urandom_range(0, 5));
      if (it.req_type == REQ_UPDATE && !small_grid) begin
        it.x_hi = HI_W'(near_hi(it.x_lo));
        it.y_hi = HI_W'(near_hi(it.y_lo));
        it.z_hi = HI_W'(near_hi(it.z_lo));
      end
      return it;
    end
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      return make_req(REQ_WRITE, $urandom_range(0, 5), $urandom_range(0, sb.lv_sx[0] - 1),
                      $urandom_range(0, sb.lv_sy[0] - 1), $urandom_range(0, sb.lv_sz[0] - 1),
                      $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                      ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 | $urandom : $urandom);
    end
    if (sel < 5) begin
      return make_req(REQ_ADD, $urandom_range(0, 5), $urandom_range(0, 2 * sb.lv_sx[0] - 1),
                      $urandom_range(0, 2 * sb.lv_sy[0] - 1),
                      $urandom_range(0, 2 * sb.lv_sz[0] - 1),
                      $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom);
    end
    lv = $urandom_range(0, sb.lv_count);
    if (lv > 5) lv = 5;
    if (sel < 8) begin
      return make_req(REQ_READ, lv, $urandom_range(0, sb.lv_sx[lv]),
                      $urandom_range(0, sb.lv_sy[lv]), $urandom_range(0, sb.lv_sz[lv]),
                      $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom);
    end
    it = make_req(REQ_UPDATE, lv, $urandom_range(0, sb.lv_sx[lv] - 1),
                  $urandom_range(0, sb.lv_sy[lv] - 1), $urandom_range(0, sb.lv_sz[lv] - 1),
                  0, 0, 0, $urandom);
    if (small_grid && $urandom_range(0, 3) == 0) begin
      it.x_lo = '0; it.y_lo = '0; it.z_lo = '0;
      it.x_hi = HI_W'(31); it.y_hi = HI_W'(31); it.z_hi = HI_W'(31);
    end else begin
      it.x_hi = HI_W'(near_hi(it.x_lo));
      it.y_hi = HI_W'(near_hi(it.y_lo));
      it.z_hi = HI_W'(near_hi(it.z_lo));
    end
    return it;
  endfunction

  // Response side: random stalls, and one long hold-off to back the block up.
  initial begin : response_side
    int stall, taken;
    out_item_t got;
    taken = 0;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = back_to_back ? 0 : $urandom_range(0, 11);
      if (taken == 60) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      got = out_item;
      @(posedge clk);
      sb.check_result(got);
      taken++;
    end
  end

  initial begin : request_side
    int sizes[7][3];
    sb = new();
    sb.init();
    back_to_back = 1'b0;
    rst = 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_BASE_X;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_item <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: saturation, vertex mapping, out-of-grid reads, region rebuilds.
    send_request(make_req(REQ_WRITE, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_request(make_req(REQ_WRITE, 5, 1, 0, 0, 31, 31, 31, 32'h0001_0000));
    send_request(make_req(REQ_ADD, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0005));
    send_request(make_req(REQ_ADD, 3, 63, 63, 63, 0, 0, 0, 32'h8000_0000));
    send_request(make_req(REQ_ADD, 0, 62, 63, 62, 0, 0, 0, 32'h8000_0001));
    send_request(make_req(REQ_WRITE, 0, 32, 0, 63, 0, 0, 0, 32'h1234_5678));
    send_request(make_req(REQ_ADD, 0, 64 - 1, 0, 0, 0, 0, 0, 32'h0000_0001));
    send_request(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, '0));
    send_request(make_req(REQ_READ, 0, 31, 31, 31, 0, 0, 0, '0));
    send_request(make_req(REQ_READ, 0, 40, 0, 0, 0, 0, 0, '0));
    send_request(make_req(REQ_UPDATE, 0, 0, 0, 0, 1, 1, 1, '0));
    send_request(make_req(REQ_UPDATE, 1, 15, 15, 15, 31, 31, 31, '0));
    send_request(make_req(REQ_UPDATE, 2, 3, 3, 3, 1, 1, 1, '0));
    send_request(make_req(REQ_READ, 1, 0, 0, 0, 0, 0, 0, '0));
    send_request(make_req(REQ_READ, 5, 0, 0, 0, 0, 0, 0, '0));
    send_request(make_req(REQ_READ, 1, 15, 15, 15, 0, 0, 0, '0));
    send_request(make_req(REQ_READ, 5, 1, 0, 0, 0, 0, 0, '0));
    write_sizes(1, 1, 1);
    send_request(make_req(REQ_READ, 1, 0, 0, 0, 0, 0, 0, '0));
    send_request(make_req(REQ_UPDATE, 5, 0, 0, 0, 31, 31, 31, '0));
    send_request(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, '0));

    // Random phases over several grid shapes, extremes included.
    sizes = '{'{1, 1, 1}, '{32, 32, 32}, '{63, 0, 5}, '{3, 7, 33},
              '{17, 32, 2}, '{5, 5, 5}, '{0, 63, 9}};
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) write_sizes(sizes[ph][0], sizes[ph][1], sizes[ph][2]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 39) == 0) back_to_back = ~back_to_back;
        send_request(random_request());
      end
    end
    in_valid <= 1'b0;
    back_to_back = 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.fails == 0 && sb.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
